### sv/slcd_pkg.sv
package slcd_pkg;

    localparam int unsigned NUM_WRITES = 16;

    typedef logic [3:0] bcd_t;

    typedef struct packed {
        logic        running;
        logic        motor_stopped;
        logic        blink_phase;
        logic        time_blank;
        logic        speed_blank;
        logic        time_is_set;
        logic        countdown_done;
        logic [18:0] set_seconds;
        logic [18:0] elapsed_seconds;
        logic [13:0] target_speed;
        logic [13:0] control_speed;
        logic [13:0] measured_speed;
    } slcd_tick_t;

    typedef struct packed {
        logic [5:0] lcd_address;
        logic [7:0] segment_byte;
        logic       last_write;
    } slcd_write_t;

    typedef struct packed {
        logic running;
        logic blink_phase;
        logic time_blank;
        logic speed_blank;
        logic time_is_set;
        logic countdown_done;
    } slcd_flags_t;

    // times saturated to 99:59, speeds saturated to 9999
    typedef struct packed {
        slcd_flags_t flags;
        logic [18:0] preset_time;
        logic [18:0] elapsed_time;
        logic [13:0] preset_speed;
        logic [13:0] shown_speed;
    } slcd_entry_t;

    typedef struct packed {
        slcd_flags_t               flags;
        logic [NUM_WRITES-1:0][3:0] digit;
    } slcd_frame_t;

endpackage

### sv/segment_lcd_speed_time_refresh.sv
// The first of the sixteen writes is registered after its request has passed the queue,
// the conversion and the write buffer; the write sequencer issues one LCD write per cycle
// while wr_ready does not stall it. Digit conversion, in separate reciprocal multipliers
// per value, overlaps the writes of the previous request; a 2-entry queue follows the front.
// Reset (rst_n, async): display mode undecided, speeds zero, offset mode 0, all queues empty.
module segment_lcd_speed_time_refresh (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    input  logic                  tick_valid,
    output logic                  tick_ready,
    input  slcd_pkg::slcd_tick_t  tick,
    output logic                  wr_valid,
    input  logic                  wr_ready,
    output slcd_pkg::slcd_write_t wr
);
    import slcd_pkg::*;

    logic        q_in_valid;
    logic        q_in_ready;
    slcd_entry_t q_in_data;
    logic        q_out_valid;
    logic        q_out_ready;
    slcd_entry_t q_out_data;
    logic        frame_valid;
    logic        frame_ready;
    slcd_frame_t frame;

    slcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick       (tick),
        .q_valid    (q_in_valid),
        .q_ready    (q_in_ready),
        .q_data     (q_in_data)
    );

    slcd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_data  (q_in_data),
        .pop_valid  (q_out_valid),
        .pop_ready  (q_out_ready),
        .pop_data   (q_out_data)
    );

    slcd_conv u_conv (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_out_valid),
        .q_ready     (q_out_ready),
        .q_data      (q_out_data),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    slcd_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .wr_valid    (wr_valid),
        .wr_ready    (wr_ready),
        .wr          (wr)
    );

endmodule

### sv/slcd_front.sv
module slcd_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data,
    input  logic                   tick_valid,
    output logic                   tick_ready,
    input  slcd_pkg::slcd_tick_t   tick,
    output logic                   q_valid,
    input  logic                   q_ready,
    output slcd_pkg::slcd_entry_t  q_data
);
    import slcd_pkg::*;

    typedef enum logic [3:0] {
        MODE_UNDEC  = 4'b0001,
        MODE_RISE   = 4'b0010,
        MODE_FALL   = 4'b0100,
        MODE_STEADY = 4'b1000
    } mode_t;

    localparam logic [13:0] SPEED_OFFSET  = 14'd500;
    localparam logic [13:0] SPEED_MAX     = 14'd9999;
    localparam logic [18:0] TIME_MAX      = 19'd359999;
    localparam logic [19:0] ELAPSED_ROUND = 20'd59;

    logic        offset_off_reg;
    mode_t       mode_reg;
    mode_t       mode_next;
    mode_t       mode_eff;
    logic [13:0] prev_reg;
    logic [13:0] prev_next;
    logic [13:0] prev_eff;
    logic [13:0] shown_reg;
    logic [13:0] shown_next;
    logic [13:0] fresh_rise;
    logic [13:0] fall_meas;
    logic [13:0] fresh_fall;
    logic [13:0] meas_less;
    logic        fall_reached;
    logic [19:0] elapsed_sum;
    logic        accept;

    assign cfg_ready  = 1'b1;
    assign tick_ready = q_ready;
    assign q_valid    = tick_valid;
    assign accept     = tick_valid && q_ready;

    always_comb
    begin
        if (mode_reg == MODE_UNDEC)
        begin
            if (tick.control_speed >= shown_reg)
            begin
                mode_eff = MODE_RISE;
                prev_eff = '0;
            end
            else
            begin
                mode_eff = MODE_FALL;
                prev_eff = shown_reg;
            end
        end
        else
        begin
            mode_eff = mode_reg;
            prev_eff = prev_reg;
        end
    end

    assign meas_less  = tick.measured_speed - SPEED_OFFSET;
    assign fresh_rise = (tick.measured_speed <= prev_eff) ? prev_eff : tick.measured_speed;

    always_comb
    begin
        if (!offset_off_reg)
        begin
            fall_reached = (tick.measured_speed < SPEED_OFFSET) ||
                           (meas_less <= tick.control_speed);
            fall_meas    = (tick.measured_speed < SPEED_OFFSET) ? '0 : meas_less;
        end
        else
        begin
            fall_reached = tick.measured_speed <= tick.control_speed;
            fall_meas    = tick.measured_speed;
        end
        fresh_fall = (fall_meas >= prev_eff) ? prev_eff : fall_meas;
    end

    always_comb
    begin
        mode_next  = mode_eff;
        prev_next  = prev_eff;
        shown_next = shown_reg;
        if (!tick.running)
        begin
            mode_next  = MODE_UNDEC;
            prev_next  = '0;
            shown_next = '0;
        end
        else
        begin
            unique case (mode_eff)
                MODE_RISE:
                begin
                    if (!tick.motor_stopped && tick.measured_speed >= tick.control_speed)
                    begin
                        mode_next = MODE_STEADY;
                    end
                    else
                    begin
                        prev_next  = fresh_rise;
                        shown_next = fresh_rise;
                    end
                end
                MODE_FALL:
                begin
                    if (!tick.motor_stopped && fall_reached)
                    begin
                        mode_next = MODE_STEADY;
                    end
                    else
                    begin
                        prev_next  = fresh_fall;
                        shown_next = fresh_fall;
                    end
                end
                MODE_STEADY:
                begin
                    shown_next = tick.control_speed;
                end
                default:
                begin
                    mode_next = MODE_UNDEC;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_off_reg <= 1'b0;
            mode_reg       <= MODE_UNDEC;
            prev_reg       <= '0;
            shown_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                offset_off_reg <= cfg_data;
            end
            if (accept)
            begin
                mode_reg  <= mode_next;
                prev_reg  <= prev_next;
                shown_reg <= shown_next;
            end
        end
    end

    assign elapsed_sum = {1'b0, tick.elapsed_seconds} + ELAPSED_ROUND;

    always_comb
    begin
        q_data.flags.running        = tick.running;
        q_data.flags.blink_phase    = tick.blink_phase;
        q_data.flags.time_blank     = tick.time_blank;
        q_data.flags.speed_blank    = tick.speed_blank;
        q_data.flags.time_is_set    = tick.time_is_set;
        q_data.flags.countdown_done = tick.countdown_done;
        q_data.preset_time  = (tick.set_seconds > TIME_MAX) ? TIME_MAX : tick.set_seconds;
        q_data.elapsed_time = (elapsed_sum > {1'b0, TIME_MAX}) ? TIME_MAX : elapsed_sum[18:0];
        q_data.preset_speed = (tick.target_speed > SPEED_MAX) ? SPEED_MAX : tick.target_speed;
        q_data.shown_speed  = (shown_next > SPEED_MAX) ? SPEED_MAX : shown_next;
    end

endmodule

### sv/slcd_fifo.sv
module slcd_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  slcd_pkg::slcd_entry_t  push_data,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output slcd_pkg::slcd_entry_t  pop_data
);
    import slcd_pkg::*;

    localparam int unsigned QUEUE_DEPTH = 2;

    slcd_entry_t slot_reg [QUEUE_DEPTH];
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic        push;
    logic        pop;

    assign push_ready = count_reg != 2'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != 2'd0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/slcd_conv.sv
module slcd_conv (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  slcd_pkg::slcd_entry_t  q_data,
    output logic                   frame_valid,
    input  logic                   frame_ready,
    output slcd_pkg::slcd_frame_t  frame
);
    import slcd_pkg::*;

    typedef enum logic [2:0] {
        CONV_IDLE = 3'b001,
        CONV_CALC = 3'b010,
        CONV_FULL = 3'b100
    } conv_state_t;

    localparam logic [2:0]  STEP_DIV_HOUR  = 3'd0;
    localparam logic [2:0]  STEP_REM_HOUR  = 3'd1;
    localparam logic [2:0]  STEP_DIV_MIN   = 3'd2;
    localparam logic [2:0]  STEP_REM_TENS  = 3'd3;
    localparam logic [2:0]  STEP_MIN_UNITS = 3'd4;
    localparam logic [2:0]  STEP_LAST      = 3'd5;

    // reciprocals: floor(x * K >> s) is exact over each value range used
    localparam logic [38:0] RECIP_3600 = 39'd596524;   // s = 31
    localparam logic [24:0] RECIP_60   = 25'd4370;     // s = 18
    localparam logic [28:0] RECIP_1000 = 29'd16778;    // s = 24
    localparam logic [19:0] RECIP_100  = 20'd656;      // s = 16
    localparam logic [14:0] RECIP_10   = 15'd205;      // s = 11

    conv_state_t state_reg;
    conv_state_t state_next;
    logic [2:0]  step_reg;
    logic        load;

    slcd_flags_t flags_reg;
    logic [18:0] tval_reg   [2];
    logic [13:0] sval_reg   [2];
    logic [6:0]  hours_reg  [2];
    logic [11:0] rem_reg    [2];
    logic [5:0]  mins_reg   [2];
    bcd_t        htens_reg  [2];
    bcd_t        hunits_reg [2];
    bcd_t        mtens_reg  [2];
    bcd_t        munits_reg [2];
    logic [9:0]  srem1_reg  [2];
    logic [6:0]  srem2_reg  [2];
    bcd_t        sth_reg    [2];
    bcd_t        shd_reg    [2];
    bcd_t        stens_reg  [2];
    bcd_t        sunits_reg [2];

    logic [38:0] hour_prod  [2];
    logic [18:0] hour_back  [2];
    logic [14:0] htens_prod [2];
    logic [6:0]  htens_back [2];
    logic [24:0] min_prod   [2];
    logic [13:0] mtens_prod [2];
    logic [5:0]  mtens_back [2];
    logic [28:0] th_prod    [2];
    logic [13:0] th_back    [2];
    logic [19:0] hd_prod    [2];
    logic [9:0]  hd_back    [2];
    logic [14:0] tens_prod  [2];
    logic [6:0]  tens_back  [2];

    assign q_ready     = (state_reg == CONV_IDLE) || (state_reg == CONV_FULL && frame_ready);
    assign load        = q_valid && q_ready;
    assign frame_valid = state_reg == CONV_FULL;

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            hour_prod[j]  = 39'(tval_reg[j]) * RECIP_3600;
            hour_back[j]  = 19'(hours_reg[j]) * 19'd3600;
            htens_prod[j] = 15'(hours_reg[j]) * RECIP_10;
            htens_back[j] = 7'(htens_reg[j]) * 7'd10;
            min_prod[j]   = 25'(rem_reg[j]) * RECIP_60;
            mtens_prod[j] = 14'(mins_reg[j]) * 14'(RECIP_10);
            mtens_back[j] = 6'(mtens_reg[j]) * 6'd10;
            th_prod[j]    = 29'(sval_reg[j]) * RECIP_1000;
            th_back[j]    = 14'(sth_reg[j]) * 14'd1000;
            hd_prod[j]    = 20'(srem1_reg[j]) * RECIP_100;
            hd_back[j]    = 10'(shd_reg[j]) * 10'd100;
            tens_prod[j]  = 15'(srem2_reg[j]) * RECIP_10;
            tens_back[j]  = 7'(stens_reg[j]) * 7'd10;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (load)
        begin
            state_next = CONV_CALC;
        end
        else if (state_reg == CONV_CALC && step_reg == STEP_LAST)
        begin
            state_next = CONV_FULL;
        end
        else if (state_reg == CONV_FULL && frame_ready)
        begin
            state_next = CONV_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CONV_IDLE;
            step_reg  <= STEP_DIV_HOUR;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                step_reg <= STEP_DIV_HOUR;
            end
            else if (state_reg == CONV_CALC)
            begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg   <= q_data.flags;
            tval_reg[0] <= q_data.preset_time;
            tval_reg[1] <= q_data.elapsed_time;
            sval_reg[0] <= q_data.preset_speed;
            sval_reg[1] <= q_data.shown_speed;
        end
        else if (state_reg == CONV_CALC)
        begin
            for (int j = 0; j < 2; j++)
            begin
                unique case (step_reg)
                    STEP_DIV_HOUR:
                    begin
                        hours_reg[j] <= hour_prod[j][37:31];
                        sth_reg[j]   <= th_prod[j][27:24];
                    end
                    STEP_REM_HOUR:
                    begin
                        rem_reg[j]   <= 12'(tval_reg[j] - hour_back[j]);
                        htens_reg[j] <= htens_prod[j][14:11];
                        srem1_reg[j] <= 10'(sval_reg[j] - th_back[j]);
                    end
                    STEP_DIV_MIN:
                    begin
                        mins_reg[j]   <= min_prod[j][23:18];
                        hunits_reg[j] <= 4'(hours_reg[j] - htens_back[j]);
                        shd_reg[j]    <= hd_prod[j][19:16];
                    end
                    STEP_REM_TENS:
                    begin
                        mtens_reg[j] <= {1'b0, mtens_prod[j][13:11]};
                        srem2_reg[j] <= 7'(srem1_reg[j] - hd_back[j]);
                    end
                    STEP_MIN_UNITS:
                    begin
                        munits_reg[j] <= 4'(mins_reg[j] - mtens_back[j]);
                        stens_reg[j]  <= tens_prod[j][14:11];
                    end
                    STEP_LAST:
                    begin
                        sunits_reg[j] <= 4'(srem2_reg[j] - tens_back[j]);
                    end
                    default:
                    begin
                        sunits_reg[j] <= sunits_reg[j];
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        frame.flags = flags_reg;
        for (int j = 0; j < 2; j++)
        begin
            frame.digit[4*j + 0]     = htens_reg[j];
            frame.digit[4*j + 1]     = hunits_reg[j];
            frame.digit[4*j + 2]     = mtens_reg[j];
            frame.digit[4*j + 3]     = munits_reg[j];
            frame.digit[8 + 4*j + 0] = sth_reg[j];
            frame.digit[8 + 4*j + 1] = shd_reg[j];
            frame.digit[8 + 4*j + 2] = stens_reg[j];
            frame.digit[8 + 4*j + 3] = sunits_reg[j];
        end
    end

endmodule

### sv/slcd_emit.sv
module slcd_emit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   frame_valid,
    output logic                   frame_ready,
    input  slcd_pkg::slcd_frame_t  frame,
    output logic                   wr_valid,
    input  logic                   wr_ready,
    output slcd_pkg::slcd_write_t  wr
);
    import slcd_pkg::*;

    localparam logic [1:0] GRP_SET_TIME  = 2'd0;
    localparam logic [1:0] GRP_ELAPSED   = 2'd1;
    localparam logic [1:0] GRP_SET_SPEED = 2'd2;
    localparam logic [1:0] GRP_SHOWN     = 2'd3;

    localparam logic [3:0] LAST_IDX = 4'(NUM_WRITES - 1);

    localparam logic [7:0] COLON_LL = 8'h80;
    localparam logic [7:0] DASH_LL  = 8'h08;
    localparam logic [7:0] DASH_UP  = 8'h10;
    localparam logic [7:0] ICON_BIT = 8'h01;

    localparam logic [5:0] LCD_ADDR [NUM_WRITES] = '{
        6'd0,  6'd2,  6'd4,  6'd6,
        6'd54, 6'd52, 6'd50, 6'd48,
        6'd26, 6'd28, 6'd30, 6'd32,
        6'd46, 6'd44, 6'd42, 6'd40
    };

    function automatic logic [7:0] font_low_left(input bcd_t d);
        logic [7:0] f;
        unique case (d)
            4'd0:    f = 8'h77;
            4'd1:    f = 8'h24;
            4'd2:    f = 8'h5d;
            4'd3:    f = 8'h6d;
            4'd4:    f = 8'h2e;
            4'd5:    f = 8'h6b;
            4'd6:    f = 8'h7b;
            4'd7:    f = 8'h25;
            4'd8:    f = 8'h7f;
            4'd9:    f = 8'h6f;
            default: f = 8'h00;
        endcase
        return f;
    endfunction

    function automatic logic [7:0] font_upper(input bcd_t d);
        logic [7:0] f;
        unique case (d)
            4'd0:    f = 8'hee;
            4'd1:    f = 8'h24;
            4'd2:    f = 8'hba;
            4'd3:    f = 8'hb6;
            4'd4:    f = 8'h74;
            4'd5:    f = 8'hd6;
            4'd6:    f = 8'hde;
            4'd7:    f = 8'ha4;
            4'd8:    f = 8'hfe;
            4'd9:    f = 8'hf6;
            default: f = 8'h00;
        endcase
        return f;
    endfunction

    function automatic logic [7:0] font_low_right(input bcd_t d);
        logic [7:0] f;
        unique case (d)
            4'd0:    f = 8'hee;
            4'd1:    f = 8'h48;
            4'd2:    f = 8'hba;
            4'd3:    f = 8'hda;
            4'd4:    f = 8'h5c;
            4'd5:    f = 8'hd6;
            4'd6:    f = 8'hf6;
            4'd7:    f = 8'h4a;
            4'd8:    f = 8'hfe;
            4'd9:    f = 8'hde;
            default: f = 8'h00;
        endcase
        return f;
    endfunction

    slcd_frame_t buf_reg;
    logic        buf_valid_reg;
    logic [3:0]  idx_reg;
    logic        wr_valid_reg;
    slcd_write_t wr_reg;
    logic        load_out;
    logic        take;
    logic        last;
    logic [1:0]  grp;
    logic [1:0]  pos;
    bcd_t        digit;
    logic        run_blink;
    logic [7:0]  seg;

    assign last        = idx_reg == LAST_IDX;
    assign load_out    = buf_valid_reg && (!wr_valid_reg || wr_ready);
    assign frame_ready = !buf_valid_reg || (load_out && last);
    assign take        = frame_valid && frame_ready;
    assign grp         = idx_reg[3:2];
    assign pos         = idx_reg[1:0];
    assign digit       = buf_reg.digit[idx_reg];
    assign run_blink   = buf_reg.flags.running && buf_reg.flags.blink_phase;
    assign wr_valid    = wr_valid_reg;
    assign wr          = wr_reg;

    always_comb
    begin
        unique case (grp)
            GRP_SET_TIME:
            begin
                if (!buf_reg.flags.time_is_set)
                begin
                    seg = (pos == 2'd1) ? (DASH_LL | COLON_LL) : DASH_LL;
                end
                else if (buf_reg.flags.time_blank)
                begin
                    seg = (pos == 2'd3) ? COLON_LL : 8'h00;
                end
                else
                begin
                    seg = font_low_left(digit) | (pos[0] ? COLON_LL : 8'h00);
                end
            end
            GRP_ELAPSED:
            begin
                if (!buf_reg.flags.time_is_set)
                begin
                    seg = DASH_UP | (pos[0] ? ICON_BIT : 8'h00);
                end
                else
                begin
                    seg = font_upper(digit) |
                          ((pos[0] && !(run_blink && !buf_reg.flags.countdown_done)) ?
                           ICON_BIT : 8'h00);
                end
            end
            GRP_SET_SPEED:
            begin
                if (buf_reg.flags.speed_blank)
                begin
                    seg = (pos == 2'd3) ? ICON_BIT : 8'h00;
                end
                else
                begin
                    seg = font_low_right(digit) | ((pos == 2'd3) ? ICON_BIT : 8'h00);
                end
            end
            GRP_SHOWN:
            begin
                seg = font_upper(digit) | ((!pos[0] && !run_blink) ? ICON_BIT : 8'h00);
            end
            default:
            begin
                seg = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            idx_reg       <= '0;
            wr_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                buf_valid_reg <= 1'b1;
            end
            else if (load_out && last)
            begin
                buf_valid_reg <= 1'b0;
            end
            if (load_out)
            begin
                idx_reg      <= idx_reg + 4'd1;
                wr_valid_reg <= 1'b1;
            end
            else if (wr_ready)
            begin
                wr_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            buf_reg <= frame;
        end
        if (load_out)
        begin
            wr_reg.lcd_address  <= LCD_ADDR[idx_reg];
            wr_reg.segment_byte <= seg;
            wr_reg.last_write   <= last;
        end
    end

endmodule
